>>> rtl/core/sts_pkg.sv
package sts_pkg;

  // Sample and result items
  typedef struct packed {
    logic [47:0] surface_normal;
    logic [47:0] view_dir;
    logic [47:0] light_dir;
    logic [47:0] radiance_rgb;
    logic [47:0] albedo_rgb;
    logic [15:0] light_visibility;
    logic [15:0] thickness_mm;
  } sample_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
  } result_t;

  // Per-item data that rides along the pipe for the color multiplies
  typedef struct packed {
    logic [47:0] radiance_rgb;
    logic [47:0] albedo_rgb;
    logic [15:0] light_visibility;
  } side_t;

  // Register indexes
  localparam logic [2:0] REG_SCATTER_RED   = 3'd0;
  localparam logic [2:0] REG_SCATTER_GREEN = 3'd1;
  localparam logic [2:0] REG_SCATTER_BLUE  = 3'd2;
  localparam logic [2:0] REG_ANISOTROPY    = 3'd3;
  localparam logic [2:0] REG_SCALE_RED     = 3'd4;
  localparam logic [2:0] REG_SCALE_GREEN   = 3'd5;
  localparam logic [2:0] REG_SCALE_BLUE    = 3'd6;
  localparam logic [2:0] REG_LOBE_POWER    = 3'd7;

  // Physical limits
  localparam logic [15:0] MAX_THICKNESS = 16'd12800;
  localparam logic [15:0] MIN_SCALING   = 16'd1;

  // Exponential and log tables (depth is a power of two)
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_BITS = $clog2(EXP_TABLE_DEPTH);

  localparam longint unsigned LN2_Q32   = 64'd2977044472;
  localparam logic [30:0]     LOG2E_Q30 = 31'd1549082005;

  // Quotient bits of the optical depth, E < 2^21 in Q.16
  localparam int QBITS = 21;

  // Pipeline stage numbers
  localparam int STG_LOBE_DONE = 8;
  localparam int STG_RAD       = 25;
  localparam int STG_ALB       = 26;
  localparam int STG_LOBE      = 27;
  localparam int STG_VIS       = 28;
  localparam int STG_LAST      = 29;

  typedef logic [16:0] exp2_tab_t [EXP_TABLE_DEPTH];
  typedef logic [15:0] log2_tab_t [EXP_TABLE_DEPTH];

  // Shift-subtract quotient, used only while building the tables
  function automatic longint unsigned quot_small(longint unsigned a, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((a >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // 2^(-k/D) in Q1.16, Taylor series of e^-x
  function automatic exp2_tab_t build_exp2();
    exp2_tab_t tab;
    longint unsigned x;
    longint unsigned term;
    longint sum;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      x = (longint'(k) * LN2_Q32) >> EXP_BITS;
      term = 64'd1 << 32;
      sum = 64'sd1 << 32;
      for (int n = 1; n <= 13; n++) begin
        term = (term * x) >> 32;
        term = quot_small(term, longint'(n));
        if ((n & 1) != 0) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      tab[k] = 17'((longint'(sum) + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  // log2(1 + k/D) in Q0.16 by repeated squaring
  function automatic log2_tab_t build_log2();
    log2_tab_t tab;
    longint unsigned y;
    longint unsigned r;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      y = (64'd1 << 30) + ((longint'(k) << 30) >> EXP_BITS);
      r = 0;
      for (int i = 1; i <= 20; i++) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          r = r | (64'd1 << (20 - i));
        end
      end
      tab[k] = 16'((r + 64'd8) >> 4);
    end
    return tab;
  endfunction

  localparam exp2_tab_t EXP2_TAB = build_exp2();
  localparam log2_tab_t LOG2_TAB = build_log2();

  // 2^-(n + k/D): zero when the integer part is past 16
  function automatic logic [16:0] exp2_shift(logic big, logic [4:0] n,
                                             logic [EXP_BITS-1:0] k);
    logic [16:0] v;
    v = EXP2_TAB[k] >> n;
    if (big || (n > 5'd16)) v = '0;
    return v;
  endfunction

endpackage

>>> rtl/core/skin_transmission_shader.sv
// Throughput: one item per cycle unless stalled; depth is set by the 21-stage
// quotient pipe that forms the optical depth in each color lane.
// The whole pipe holds when the final result is stalled.
// Reset (rst, synchronous) clears all valid bits and loads register defaults.
module skin_transmission_shader (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  sts_pkg::sample_t  sample,
  output logic              result_valid,
  input  logic              result_stall,
  output sts_pkg::result_t  result,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int LAST = sts_pkg::STG_LAST;

  logic [15:0] scatter [3];
  logic [15:0] scale [3];
  logic [15:0] anisotropy;
  logic [15:0] power;

  logic             en;
  logic [LAST:0]    valid;
  logic [47:0]      nrm0, view0, lgt0;
  logic [15:0]      thick0;
  sts_pkg::side_t   side [sts_pkg::STG_VIS+1];
  logic [16:0]      lobe;
  logic [15:0]      chan [3];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        scatter[c] <= '0;
        scale[c]   <= 16'd256;
      end
      anisotropy <= '0;
      power      <= 16'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        sts_pkg::REG_SCATTER_RED:   scatter[0] <= cfg_data;
        sts_pkg::REG_SCATTER_GREEN: scatter[1] <= cfg_data;
        sts_pkg::REG_SCATTER_BLUE:  scatter[2] <= cfg_data;
        sts_pkg::REG_ANISOTROPY:    anisotropy <= cfg_data;
        sts_pkg::REG_SCALE_RED:     scale[0]   <= cfg_data;
        sts_pkg::REG_SCALE_GREEN:   scale[1]   <= cfg_data;
        sts_pkg::REG_SCALE_BLUE:    scale[2]   <= cfg_data;
        sts_pkg::REG_LOBE_POWER:    power      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipe advances unless the final result is held
  assign en = !valid[LAST] || !result_stall;
  assign sample_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else if (en) valid <= {valid[LAST-1:0], sample_valid};
  end

  // Input stage and per-item side data
  always_ff @(posedge clk) begin
    if (en) begin
      nrm0   <= sample.surface_normal;
      view0  <= sample.view_dir;
      lgt0   <= sample.light_dir;
      thick0 <= sample.thickness_mm;
      side[0] <= '{radiance_rgb: sample.radiance_rgb, albedo_rgb: sample.albedo_rgb,
                   light_visibility: sample.light_visibility};
      for (int i = 1; i <= sts_pkg::STG_VIS; i++) side[i] <= side[i-1];
    end
  end

  sts_lobe u_lobe (
    .clk        (clk),
    .en         (en),
    .normal     (nrm0),
    .view       (view0),
    .light      (lgt0),
    .thick      (thick0),
    .anisotropy (anisotropy),
    .power      (power),
    .lobe       (lobe)
  );

  for (genvar c = 0; c < 3; c++) begin : g_lane
    sts_lane u_lane (
      .clk     (clk),
      .en      (en),
      .thick   (thick0),
      .scatter (scatter[c]),
      .scale   (scale[c]),
      .rad     (side[sts_pkg::STG_RAD].radiance_rgb[16*c +: 16]),
      .alb     (side[sts_pkg::STG_ALB].albedo_rgb[16*c +: 16]),
      .vis     (side[sts_pkg::STG_VIS].light_visibility),
      .lobe    (lobe),
      .chan    (chan[c])
    );
  end

  assign result_valid = valid[LAST];
  assign result = '{out_red: chan[0], out_green: chan[1], out_blue: chan[2]};

endmodule

>>> rtl/core/sts_lobe.sv
// Transmission lobe: back-facing term, forward term raised to the power,
// blended by anisotropy. Result is delayed to line up with the color chain.
module sts_lobe (
  input  logic        clk,
  input  logic        en,
  input  logic [47:0] normal,
  input  logic [47:0] view,
  input  logic [47:0] light,
  input  logic [15:0] thick,
  input  logic [15:0] anisotropy,
  input  logic [15:0] power,
  output logic [16:0] lobe
);

  localparam int DLY = sts_pkg::STG_LOBE - sts_pkg::STG_LOBE_DONE;
  localparam int EB = sts_pkg::EXP_BITS;

  // clamp(-dot, 0, 1) from Q2.28 to Q0.16
  function automatic logic [16:0] neg_clamp(logic signed [33:0] dot);
    logic signed [34:0] v;
    logic [16:0] r;
    v = -(35'(dot));
    if (v < 0) r = '0;
    else if (v > 35'sd268435456) r = 17'h10000;
    else r = v[28:12];
    return r;
  endfunction

  logic signed [31:0] prod_nl [3];
  logic signed [31:0] prod_vl [3];
  logic               black1;
  logic signed [33:0] dot_nl;
  logic signed [33:0] dot_vl;
  logic [16:0]        back_nl;

  logic [16:0]         back2, fwd2;
  logic                black2;
  logic [3:0]          msb;
  logic [15:0]         norm;

  logic [16:0]         back3;
  logic                black3, fz3, fone3;
  logic [3:0]          m3;
  logic [EB-1:0]       k3;

  logic [16:0]         back4;
  logic                black4, fz4, fone4;
  logic [20:0]         l4;

  logic [15:0]         pw;
  logic [16:0]         back5;
  logic                black5, fz5, fone5;
  logic [36:0]         el5;
  logic [28:0]         e5;

  logic [16:0]         back6, dir6;
  logic                black6;
  logic [32:0]         blend;

  logic [16:0]         back7, shape7;
  logic                black7;
  logic [33:0]         lobe_prod;

  logic [16:0]         lobe8;
  logic [16:0]         dly [DLY];

  // Stage 1: component products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        prod_nl[c] <= $signed(normal[16*c +: 16]) * $signed(light[16*c +: 16]);
        prod_vl[c] <= $signed(view[16*c +: 16]) * $signed(light[16*c +: 16]);
      end
      black1 <= (thick == '0);
    end
  end

  // Stage 2: dot sums and clamp
  always_comb begin
    dot_nl = 34'(prod_nl[0]) + 34'(prod_nl[1]) + 34'(prod_nl[2]);
    dot_vl = 34'(prod_vl[0]) + 34'(prod_vl[1]) + 34'(prod_vl[2]);
    back_nl = neg_clamp(dot_nl);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      back2  <= back_nl;
      fwd2   <= neg_clamp(dot_vl);
      black2 <= black1 || (back_nl == '0);
    end
  end

  // Stage 3: normalize the forward term
  always_comb begin
    msb = '0;
    for (int i = 0; i < 16; i++) begin
      if (fwd2[i]) msb = 4'(i);
    end
    norm = fwd2[15:0] << (4'd15 - msb);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      back3  <= back2;
      black3 <= black2;
      fz3    <= (fwd2 == '0);
      fone3  <= fwd2[16];
      m3     <= msb;
      k3     <= norm[14 -: EB];
    end
  end

  // Stage 4: -log2(fwd) in Q.16
  always_ff @(posedge clk) begin
    if (en) begin
      back4  <= back3;
      black4 <= black3;
      fz4    <= fz3;
      fone4  <= fone3;
      l4     <= (21'(5'd16 - {1'b0, m3}) << 16) - 21'(sts_pkg::LOG2_TAB[k3]);
    end
  end

  // Stage 5: scale by the power (at least one)
  assign pw = (power < 16'd256) ? 16'd256 : power;

  always_ff @(posedge clk) begin
    if (en) begin
      back5  <= back4;
      black5 <= black4;
      fz5    <= fz4;
      fone5  <= fone4;
      el5    <= 37'(l4) * 37'(pw);
    end
  end

  // Stage 6: 2^-e
  assign e5 = el5[36:8];

  always_ff @(posedge clk) begin
    if (en) begin
      back6  <= back5;
      black6 <= black5;
      if (fz5) dir6 <= '0;
      else if (fone5) dir6 <= 17'h10000;
      else dir6 <= sts_pkg::exp2_shift(|e5[28:21], e5[20:16], e5[15 -: EB]);
    end
  end

  // Stage 7: blend flat and directional
  assign blend = (33'(17'h10000 - 17'(anisotropy)) << 16)
               + 33'(anisotropy) * 33'(dir6);

  always_ff @(posedge clk) begin
    if (en) begin
      back7  <= back6;
      black7 <= black6;
      shape7 <= blend[32:16];
    end
  end

  // Stage 8: weight by the back-facing term; black items get a zero lobe
  assign lobe_prod = 34'(back7) * 34'(shape7);

  always_ff @(posedge clk) begin
    if (en) begin
      lobe8 <= black7 ? '0 : lobe_prod[32:16];
    end
  end

  // Align with the color chain
  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= lobe8;
      for (int i = 1; i < DLY; i++) dly[i] <= dly[i-1];
    end
  end

  assign lobe = dly[DLY-1];

endmodule

>>> rtl/core/sts_lane.sv
// One color channel: optical depth by a stepped quotient pipe, survival
// from the exp table, then the chain of truncating multiplies.
module sts_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] thick,
  input  logic [15:0] scatter,
  input  logic [15:0] scale,
  input  logic [15:0] rad,
  input  logic [15:0] alb,
  input  logic [15:0] vis,
  input  logic [16:0] lobe,
  output logic [15:0] chan
);

  localparam int QB = sts_pkg::QBITS;
  localparam int EB = sts_pkg::EXP_BITS;

  logic [15:0]  t0;
  logic [15:0]  s;
  logic [46:0]  prod1;
  logic [15:0]  rem [QB+1];
  logic [QB-1:0] num [QB+1];
  logic         ovf [QB+1];
  logic [16:0]  surv;
  logic [32:0]  tr_prod;
  logic [15:0]  tr;
  logic [31:0]  x1_prod;
  logic [17:0]  x1;
  logic [33:0]  x2_prod;
  logic [17:0]  x2;
  logic [34:0]  x3_prod;
  logic [17:0]  x3;
  logic [33:0]  x4_prod;

  assign t0 = (thick > sts_pkg::MAX_THICKNESS) ? sts_pkg::MAX_THICKNESS : thick;
  assign s  = (scale < sts_pkg::MIN_SCALING) ? sts_pkg::MIN_SCALING : scale;

  // Stage 1: t * log2(e)
  always_ff @(posedge clk) begin
    if (en) prod1 <= 47'(t0) * 47'(sts_pkg::LOG2E_Q30);
  end

  // Stage 2: quotient setup, overflow when E >= 2^21
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= 16'(prod1[46:35]);
      num[0] <= prod1[34:14];
      ovf[0] <= ({4'b0, prod1[46:35]} >= s);
    end
  end

  // One quotient bit per stage
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [16:0] trial;
    logic        ge;
    assign trial = {rem[j], num[j][QB-1]};
    assign ge = (trial >= {1'b0, s});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? 16'(trial - {1'b0, s}) : trial[15:0];
        num[j+1] <= {num[j][QB-2:0], ge};
        ovf[j+1] <= ovf[j];
      end
    end
  end

  // Survival 2^-E
  always_ff @(posedge clk) begin
    if (en) surv <= sts_pkg::exp2_shift(ovf[QB], num[QB][20:16], num[QB][15 -: EB]);
  end

  // Color chain, one multiply per stage
  assign tr_prod = 33'(scatter) * 33'(surv);
  assign x1_prod = 32'(rad) * 32'(tr);
  assign x2_prod = 34'(x1) * 34'(alb);
  assign x3_prod = 35'(x2) * 35'(lobe);
  assign x4_prod = 34'(x3) * 34'(vis);

  always_ff @(posedge clk) begin
    if (en) begin
      tr <= tr_prod[31:16];
      x1 <= x1_prod[31:14];
      x2 <= x2_prod[33:16];
      x3 <= x3_prod[33:16];
      chan <= (x4_prod[33:32] != 2'b00) ? 16'hFFFF : x4_prod[31:16];
    end
  end

endmodule

>>> rtl/core/sts_checker.sv
module sts_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_valid,
  input logic             sample_stall,
  input logic             result_valid,
  input logic             result_stall,
  input sts_pkg::result_t result
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (result_valid && result_stall))
    else $error("sample stalled without a held result");

  // A held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("held result changed");

  // With output free, the block takes a new item
  a_free_flow: assert property (@(posedge clk) disable iff (rst)
    (!result_valid && sample_valid) |-> !sample_stall)
    else $error("sample stalled with empty output");

endmodule

bind skin_transmission_shader sts_checker u_sts_checker (.*);

>>> tb/sv/skin_transmission_checker.sv
`timescale 1ns / 100ps

module skin_transmission_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  input  logic             sample_stall,
  input  sts_pkg::sample_t sample,
  input  logic             result_valid,
  input  logic             result_stall,
  input  sts_pkg::result_t result,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output int               errors,
  output int               pending
);

  localparam longint unsigned DEPTH = 256;
  localparam longint unsigned LOG2E = 64'd1549082005;
  localparam longint unsigned LN2   = 64'd2977044472;
  localparam longint unsigned T_MAX = 12800;
  localparam longint unsigned S_MIN = 1;

  longint unsigned pow2_neg_tab [256];
  longint unsigned log2_frac_tab [256];

  // register copies
  logic [15:0] scat_r, scat_g, scat_b, aniso, scl_r, scl_g, scl_b, lpow;

  sts_pkg::result_t expected_q [$];

  // both lookup tables, built once
  initial begin
    longint unsigned x, term, y, r;
    longint sum;
    for (int k = 0; k < 256; k++) begin
      x = (longint'(k) * LN2) / DEPTH;
      term = 64'd1 << 32;
      sum = 64'sd1 << 32;
      for (int n = 1; n <= 13; n++) begin
        term = (term * x) >> 32;
        term = term / n;
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      pow2_neg_tab[k] = (longint'(sum) + 32768) >> 16;
      y = (64'd1 << 30) + ((longint'(k) << 30) / DEPTH);
      r = 0;
      for (int i = 1; i <= 20; i++) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          r = r | (64'd1 << (20 - i));
        end
      end
      log2_frac_tab[k] = (r + 8) >> 4;
    end
  end

  function automatic longint comp(logic [47:0] v, int c);
    logic signed [15:0] s;
    s = v[16*c +: 16];
    return longint'(s);
  endfunction

  // clamp(-a.b, 0, 1) in Q0.16
  function automatic longint unsigned facing(logic [47:0] a, logic [47:0] b);
    longint d;
    d = 0;
    for (int c = 0; c < 3; c++) d = d + comp(a, c) * comp(b, c);
    d = -d;
    if (d < 0) d = 0;
    if (d > (64'sd1 << 28)) d = 64'sd1 << 28;
    return longint'(d) >> 12;
  endfunction

  function automatic longint unsigned pow2_neg(longint unsigned e);
    longint unsigned n, k;
    n = e >> 16;
    k = ((e & 64'hFFFF) * DEPTH) >> 16;
    if (n > 16) return 0;
    if (k >= DEPTH) k = DEPTH - 1;
    return pow2_neg_tab[k] >> n;
  endfunction

  function automatic longint unsigned lobe_pow(longint unsigned f, longint unsigned p);
    int m;
    longint unsigned frac, k, l;
    m = 15;
    if (f == 0) return 0;
    if (f >= 65536) return 65536;
    while (f[m] == 1'b0) m--;
    frac = ((f << (15 - m)) & 64'hFFFF_FFFF) - 32768;
    k = (frac * DEPTH) >> 15;
    if (k >= DEPTH) k = DEPTH - 1;
    l = (longint'(16 - m) << 16) - log2_frac_tab[k];
    return pow2_neg((l * p) >> 8);
  endfunction

  function automatic logic [15:0] color(logic [15:0] scat, logic [15:0] scl,
                                        longint unsigned t, logic [15:0] rad,
                                        logic [15:0] alb, longint unsigned lobe,
                                        logic [15:0] vis);
    longint unsigned s, e, x;
    s = scl;
    if (s < S_MIN) s = S_MIN;
    if (s == 0) s = 1;
    e = (t * LOG2E) / (s << 14);
    x = (longint'(scat) * pow2_neg(e)) >> 16;
    x = (longint'(rad) * x) >> 14;
    x = (x * alb) >> 16;
    x = (x * lobe) >> 16;
    x = (x * vis) >> 16;
    return (x > 65535) ? 16'hFFFF : x[15:0];
  endfunction

  function automatic sts_pkg::result_t transmitted(sts_pkg::sample_t s);
    sts_pkg::result_t o;
    longint unsigned back, fwd, p, dir, a, shape, lobe, t;
    o = '0;
    if (s.thickness_mm == 0) return o;
    back = facing(s.surface_normal, s.light_dir);
    if (back == 0) return o;
    fwd = facing(s.view_dir, s.light_dir);
    p = (lpow < 256) ? 256 : lpow;
    dir = lobe_pow(fwd, p);
    a = aniso;
    shape = (((65536 - a) << 16) + a * dir) >> 16;
    lobe = (back * shape) >> 16;
    t = (s.thickness_mm > T_MAX) ? T_MAX : s.thickness_mm;
    o.out_red   = color(scat_r, scl_r, t, s.radiance_rgb[15:0], s.albedo_rgb[15:0],
                        lobe, s.light_visibility);
    o.out_green = color(scat_g, scl_g, t, s.radiance_rgb[31:16], s.albedo_rgb[31:16],
                        lobe, s.light_visibility);
    o.out_blue  = color(scat_b, scl_b, t, s.radiance_rgb[47:32], s.albedo_rgb[47:32],
                        lobe, s.light_visibility);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    sts_pkg::result_t want;
    if (rst) begin
      errors = 0;
      scat_r <= 0; scat_g <= 0; scat_b <= 0; aniso <= 0;
      scl_r <= 256; scl_g <= 256; scl_b <= 256; lpow <= 256;
      expected_q.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          sts_pkg::REG_SCATTER_RED:   scat_r <= cfg_data;
          sts_pkg::REG_SCATTER_GREEN: scat_g <= cfg_data;
          sts_pkg::REG_SCATTER_BLUE:  scat_b <= cfg_data;
          sts_pkg::REG_ANISOTROPY:    aniso  <= cfg_data;
          sts_pkg::REG_SCALE_RED:     scl_r  <= cfg_data;
          sts_pkg::REG_SCALE_GREEN:   scl_g  <= cfg_data;
          sts_pkg::REG_SCALE_BLUE:    scl_b  <= cfg_data;
          sts_pkg::REG_LOBE_POWER:    lpow   <= cfg_data;
          default: ;
        endcase
      end
      // accepted samples
      if (sample_valid && !sample_stall) expected_q.push_back(transmitted(sample));
      // accepted results
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result item %h at %0t", result, $realtime);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (result.out_red !== want.out_red)
            report_mismatch("out_red", result.out_red, want.out_red);
          if (result.out_green !== want.out_green)
            report_mismatch("out_green", result.out_green, want.out_green);
          if (result.out_blue !== want.out_blue)
            report_mismatch("out_blue", result.out_blue, want.out_blue);
        end
      end
    end
  end

  always @(negedge clk) pending = expected_q.size();

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic       clk;
  logic       rst;
  logic       sample_valid;
  logic       sample_stall;
  sts_pkg::sample_t sample;
  logic       result_valid;
  logic       result_stall;
  sts_pkg::result_t result;
  logic       cfg_write;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  int         errors;
  int         pending;
  idle_mode_t mode;
  int         hold_req;

  skin_transmission_shader dut (
    .clk, .rst, .sample_valid, .sample_stall, .sample,
    .result_valid, .result_stall, .result, .cfg_write, .cfg_index, .cfg_data
  );

  skin_transmission_checker checker_i (
    .clk, .rst, .sample_valid, .sample_stall, .sample,
    .result_valid, .result_stall, .result, .cfg_write, .cfg_index, .cfg_data,
    .errors, .pending
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    result_stall = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        result_stall <= 1;
        hold--;
      end else if (mode == IDLE_RECV || mode == IDLE_BOTH) begin
        result_stall <= ($urandom_range(99) < ((mode == IDLE_BOTH) ? 29 : 59));
      end else begin
        result_stall <= 0;
      end
    end
  end

  function automatic logic [47:0] vec(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic logic [47:0] rnd48();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic send(sts_pkg::sample_t s);
    int pct;
    pct = (mode == IDLE_BOTH) ? 29 : 59;
    if (mode == IDLE_SEND || mode == IDLE_BOTH) begin
      while ($urandom_range(99) < pct) begin
        sample_valid <= 0;
        @(posedge clk);
      end
    end
    sample_valid <= 1;
    sample <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] v [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1;
      cfg_index <= i[2:0];
      cfg_data <= v[i];
      @(posedge clk);
    end
    cfg_write <= 0;
  endtask

  task automatic drain();
    sample_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // a mostly back-lit sample with random content
  function automatic sts_pkg::sample_t lit_sample();
    sts_pkg::sample_t s;
    int lx, ly, lz, amp;
    amp = $urandom_range(16384, 2000);
    lx = $urandom_range(2 * amp) - amp;
    ly = $urandom_range(2 * amp) - amp;
    lz = $urandom_range(2 * amp) - amp;
    s.light_dir = vec(lx, ly, lz);
    s.surface_normal = vec(-lx + $urandom_range(4000) - 2000,
                           -ly + $urandom_range(4000) - 2000, -lz);
    s.view_dir = vec(-lx + $urandom_range(8000) - 4000, -ly,
                     -lz + $urandom_range(8000) - 4000);
    s.radiance_rgb = rnd48();
    s.albedo_rgb = rnd48();
    s.light_visibility = 16'($urandom());
    case ($urandom_range(3))
      0: s.thickness_mm = 16'($urandom());
      1: s.thickness_mm = 16'($urandom_range(1024));
      default: s.thickness_mm = 16'($urandom_range(12800));
    endcase
    return s;
  endfunction

  function automatic sts_pkg::sample_t noise_sample();
    sts_pkg::sample_t s;
    s.surface_normal = rnd48();
    s.view_dir = rnd48();
    s.light_dir = rnd48();
    s.radiance_rgb = rnd48();
    s.albedo_rgb = rnd48();
    s.light_visibility = 16'($urandom());
    s.thickness_mm = 16'($urandom());
    return s;
  endfunction

  initial begin
    logic [15:0] regs [8];
    sts_pkg::sample_t s;
    mode = IDLE_NONE;
    hold_req = 0;
    rst = 1;
    sample_valid = 0;
    sample = '0;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults first (all black), then a bright setting
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        regs = '{16'hFFFF, 16'h4000, 16'h8000, 16'h8000,
                 16'hFFFF, 16'h0100, 16'h0000, 16'h0000};
        drain();
        write_regs(regs);
      end
      s.surface_normal = vec(0, 0, -16384);
      s.view_dir = vec(0, 0, -16384);
      s.light_dir = vec(0, 0, 16384);
      s.radiance_rgb = 48'hFFFF_FFFF_FFFF;
      s.albedo_rgb = 48'hFFFF_FFFF_FFFF;
      s.light_visibility = 16'hFFFF;
      s.thickness_mm = 16'h0001;
      send(s);                                   // forward term of one
      s.thickness_mm = 16'h0000;
      send(s);                                   // missing thickness
      s.thickness_mm = 16'hFFFF;
      send(s);                                   // thick skin clamp
      s.thickness_mm = 16'd12800;
      send(s);
      s.view_dir = vec(16384, 0, 0);
      s.thickness_mm = 16'h0080;
      send(s);                                   // zero forward term
      s.surface_normal = vec(0, 0, 16384);
      send(s);                                   // front lit
      s.surface_normal = vec(-32768, -32768, -32768);
      s.light_dir = vec(32767, 32767, 32767);
      s.view_dir = vec(-32768, -32768, -32768);
      send(s);                                   // unnormalized, clamped
      s.radiance_rgb = '0;
      s.albedo_rgb = '0;
      s.light_visibility = '0;
      send(s);
      s.surface_normal = vec(-5000, 3000, -9000);
      s.light_dir = vec(6000, -2000, 11000);
      s.view_dir = vec(-8000, 1000, -7000);
      s.radiance_rgb = 48'h1234_8000_FFFF;
      s.albedo_rgb = 48'hC000_4000_FFFF;
      s.light_visibility = 16'h8000;
      send(s);                                   // partial forward term
    end
    drain();

    // random phases over several register settings and idling modes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: regs = '{16'h4000, 16'h2000, 16'h6000, 16'h0000,
                    16'h0100, 16'h0200, 16'h0080, 16'h0100};
        1: regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        2: regs = '{16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000};
        3: regs = '{16'h8000, 16'hC000, 16'h3000, 16'h8000,
                    16'h0001, 16'h0400, 16'h1000, 16'h0380};
        default: for (int i = 0; i < 8; i++) regs[i] = 16'($urandom());
      endcase
      write_regs(regs);
      mode = idle_mode_t'(ph % 4);
      if (ph == 4) begin
        mode = IDLE_NONE;
        hold_req = 300;
      end
      for (int n = 0; n < 260; n++) begin
        if ($urandom_range(9) < 8) send(lit_sample());
        else send(noise_sample());
      end
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sts_pkg.sv
rtl/core/sts_lobe.sv
rtl/core/sts_lane.sv
rtl/core/skin_transmission_shader.sv
rtl/core/sts_checker.sv
tb/sv/skin_transmission_checker.sv
tb/sv/testbench.sv
